// ===== rtl/rtaw_pkg.sv =====
`timescale 1ns / 1ps
// Package for the rotozoom texture address walker.
// Holds field widths, register reset values, register indexes, the state
// encodings of the reduction sweep and the result type. No dependencies.
package rtaw_pkg;

  localparam int FRAC_W      = 16;
  localparam int FRAC_OUT_W  = 8;
  localparam int DIM_REG_W   = 13;
  localparam int STEP_W      = 24;
  localparam int REG_W       = 28;
  localparam int REG_INT_W   = REG_W - FRAC_W;
  localparam int CNT_W       = 12;
  localparam int IDX_W       = 24;

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = REG_W;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = IDX_W + 2 * FRAC_OUT_W;
  localparam int OUT_TUSER_W = 2;

  localparam logic [DIM_REG_W-1:0] RST_FRAME_WIDTH  = 13'd320;
  localparam logic [DIM_REG_W-1:0] RST_FRAME_HEIGHT = 13'd240;
  localparam logic [STEP_W-1:0]    RST_COL_STEP_S   = 24'd65536;
  localparam logic [STEP_W-1:0]    RST_COL_STEP_T   = 24'd0;
  localparam logic [REG_W-1:0]     RST_ROW_STEP_S   = 28'd0;
  localparam logic [REG_W-1:0]     RST_ROW_STEP_T   = 28'd65536;
  localparam logic [REG_W-1:0]     RST_START_S      = 28'd0;
  localparam logic [REG_W-1:0]     RST_START_T      = 28'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 3'd0,
    CFG_FRAME_HEIGHT = 3'd1,
    CFG_COL_STEP_S   = 3'd2,
    CFG_COL_STEP_T   = 3'd3,
    CFG_ROW_STEP_S   = 3'd4,
    CFG_ROW_STEP_T   = 3'd5,
    CFG_START_S      = 3'd6,
    CFG_START_T      = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    SW_IDLE,
    SW_WAIT,
    SW_LOAD,
    SW_RUN
  } sweep_e;

  typedef enum logic [1:0] {
    SL_START,
    SL_STEP,
    SL_ROW,
    SL_PIX
  } slot_e;

  typedef struct packed {
    logic [DIM_REG_W-1:0]     frame_width;
    logic [DIM_REG_W-1:0]     frame_height;
    logic signed [STEP_W-1:0] col_step_s;
    logic signed [STEP_W-1:0] col_step_t;
    logic [REG_W-1:0]         row_step_s;
    logic [REG_W-1:0]         row_step_t;
    logic [REG_W-1:0]         start_s;
    logic [REG_W-1:0]         start_t;
  } cfg_regs_t;

  typedef struct packed {
    logic [IDX_W-1:0]      source_index;
    logic [FRAC_OUT_W-1:0] frac_s;
    logic [FRAC_OUT_W-1:0] frac_t;
    logic                  row_end;
    logic                  frame_end;
    logic                  skipped;
  } res_t;

endpackage

// ===== rtl/rtaw_rem.sv =====
`timescale 1ns / 1ps
// Iterative remainder unit: one dividend bit per cycle, restoring form.
// Used to reduce integer coordinate parts modulo the wrap period. Uses no package.
module rtaw_rem #(
  parameter int DIV_W = 12,
  parameter int REM_W = 12
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] dividend_i,
  input  logic [REM_W-1:0] divisor_i,
  output logic             done_o,
  output logic [REM_W-1:0] rem_o
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [CNT_W-1:0] cnt_q;
  logic             done_q;
  logic [DIV_W-1:0] dvd_q;
  logic [REM_W-1:0] rem_q, rem_d;
  logic [REM_W-1:0] dsr_q;
  logic [REM_W:0]   trial;

  always_comb begin
    trial = {rem_q, dvd_q[DIV_W-1]};
    if (trial >= {1'b0, dsr_q}) begin
      rem_d = REM_W'(trial - {1'b0, dsr_q});
    end else begin
      rem_d = REM_W'(trial);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CNT_W'(DIV_W);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (cnt_q != '0) begin
      dvd_q <= {dvd_q[DIV_W-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = (dsr_q == '0) ? '0 : rem_q;

endmodule

// ===== rtl/rtaw_cfg.sv =====
`timescale 1ns / 1ps
// Configuration register file with registered derived values: clamped width,
// integer wrap periods and the column step skip flag. Depends on rtaw_pkg.
module rtaw_cfg import rtaw_pkg::*; #(
  parameter  int MAX_DIM = 4096,
  localparam int DIM_W   = $clog2(MAX_DIM + 1),
  localparam int PINT_W  = $clog2(MAX_DIM)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_regs_t             regs_o,
  output logic [DIM_W-1:0]      width_o,
  output logic [PINT_W-1:0]     ps_int_o,
  output logic [PINT_W-1:0]     pt_int_o,
  output logic                  skip_o
);

  localparam int POS_W  = PINT_W + FRAC_W;
  localparam int CMP_W  = (POS_W > STEP_W) ? POS_W : STEP_W;
  localparam int RST_WD = (int'(RST_FRAME_WIDTH) > MAX_DIM) ? MAX_DIM : int'(RST_FRAME_WIDTH);
  localparam int RST_HT = (int'(RST_FRAME_HEIGHT) > MAX_DIM) ? MAX_DIM : int'(RST_FRAME_HEIGHT);

  cfg_regs_t         regs_q;
  logic [DIM_W-1:0]  width_q, width_d, height_d;
  logic [PINT_W-1:0] ps_int_q, ps_int_d, pt_int_q, pt_int_d;
  logic              skip_q, skip_d;
  logic [STEP_W-1:0] mag_s, mag_t;
  logic [DIM_W-1:0]  wm1, hm1;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_REG_W-1:0] d);
    if (d == '0) begin
      return DIM_W'(1);
    end
    if (32'(d) > 32'(MAX_DIM)) begin
      return DIM_W'(MAX_DIM);
    end
    return DIM_W'(d);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q.frame_width  <= RST_FRAME_WIDTH;
      regs_q.frame_height <= RST_FRAME_HEIGHT;
      regs_q.col_step_s   <= RST_COL_STEP_S;
      regs_q.col_step_t   <= RST_COL_STEP_T;
      regs_q.row_step_s   <= RST_ROW_STEP_S;
      regs_q.row_step_t   <= RST_ROW_STEP_T;
      regs_q.start_s      <= RST_START_S;
      regs_q.start_t      <= RST_START_T;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_FRAME_WIDTH:  regs_q.frame_width  <= cfg_data_i[DIM_REG_W-1:0];
        CFG_FRAME_HEIGHT: regs_q.frame_height <= cfg_data_i[DIM_REG_W-1:0];
        CFG_COL_STEP_S:   regs_q.col_step_s   <= cfg_data_i[STEP_W-1:0];
        CFG_COL_STEP_T:   regs_q.col_step_t   <= cfg_data_i[STEP_W-1:0];
        CFG_ROW_STEP_S:   regs_q.row_step_s   <= cfg_data_i;
        CFG_ROW_STEP_T:   regs_q.row_step_t   <= cfg_data_i;
        CFG_START_S:      regs_q.start_s      <= cfg_data_i;
        CFG_START_T:      regs_q.start_t      <= cfg_data_i;
        default:          regs_q.start_t      <= regs_q.start_t;
      endcase
    end
  end

  always_comb begin
    width_d  = clamp_dim(regs_q.frame_width);
    height_d = clamp_dim(regs_q.frame_height);
    wm1      = width_d - DIM_W'(1);
    hm1      = height_d - DIM_W'(1);
    ps_int_d = PINT_W'(wm1);
    pt_int_d = PINT_W'(hm1);
    mag_s    = regs_q.col_step_s[STEP_W-1] ? (~regs_q.col_step_s + STEP_W'(1))
                                           : regs_q.col_step_s;
    mag_t    = regs_q.col_step_t[STEP_W-1] ? (~regs_q.col_step_t + STEP_W'(1))
                                           : regs_q.col_step_t;
    skip_d   = (CMP_W'(mag_s) >= CMP_W'({ps_int_d, {FRAC_W{1'b0}}})) ||
               (CMP_W'(mag_t) >= CMP_W'({pt_int_d, {FRAC_W{1'b0}}}));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_W'(RST_WD);
      ps_int_q <= PINT_W'(RST_WD - 1);
      pt_int_q <= PINT_W'(RST_HT - 1);
      skip_q   <= 1'b0;
    end else begin
      width_q  <= width_d;
      ps_int_q <= ps_int_d;
      pt_int_q <= pt_int_d;
      skip_q   <= skip_d;
    end
  end

  assign regs_o   = regs_q;
  assign width_o  = width_q;
  assign ps_int_o = ps_int_q;
  assign pt_int_o = pt_int_q;
  assign skip_o   = skip_q;

endmodule

// ===== rtl/rtaw_walk.sv =====
`timescale 1ns / 1ps
// Coordinate walk: input stage, single-pass address datapath, result register,
// and the sweep that reduces stored positions after a register write.
// Depends on rtaw_pkg and rtaw_rem.
module rtaw_walk import rtaw_pkg::*; #(
  parameter  int MAX_DIM = 4096,
  localparam int DIM_W   = $clog2(MAX_DIM + 1),
  localparam int PINT_W  = $clog2(MAX_DIM)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  input  logic              s_new_frame_i,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  output res_t              m_res_o,
  input  logic              cfg_we_i,
  input  cfg_regs_t         regs_i,
  input  logic [DIM_W-1:0]  width_i,
  input  logic [PINT_W-1:0] ps_int_i,
  input  logic [PINT_W-1:0] pt_int_i,
  input  logic              skip_i
);

  localparam int POS_W  = PINT_W + FRAC_W;
  localparam int DIV_W  = (PINT_W > REG_INT_W) ? PINT_W : REG_INT_W;
  localparam int CMPC_W = (PINT_W > CNT_W) ? PINT_W : CNT_W;
  localparam int ADV_W  = ((POS_W > STEP_W) ? POS_W : STEP_W) + 2;
  localparam int MUL_W  = PINT_W + DIM_W;
  localparam int IDXC_W = (MUL_W + 1 > IDX_W) ? MUL_W + 1 : IDX_W;

  logic in_vld_q, in_nf_q;
  logic out_vld_q;
  res_t res_q, res_d;
  logic fire;

  logic [POS_W-1:0] row_s_q, row_t_q, pix_s_q, pix_t_q;
  logic [CNT_W-1:0] col_q, row_q;
  logic [POS_W-1:0] start_s_red_q, start_t_red_q, step_s_red_q, step_t_red_q;

  logic [POS_W-1:0] cur_s, cur_t, base_s, base_t;
  logic [CNT_W-1:0] col_cur, row_cur;
  logic [POS_W-1:0] ps_full, pt_full;
  logic [POS_W:0]   sum_s, sum_t;
  logic [POS_W-1:0] rnext_s, rnext_t;
  logic [IDXC_W-1:0] idx_c;
  logic             rend, fend;
  logic [POS_W-1:0] rs_n, rt_n, ps_n, pt_n;
  logic [CNT_W-1:0] col_n, row_n;

  sweep_e sw_q, sw_d;
  slot_e  slot_q, slot_d;
  logic   lane_start, wb, sweep_idle;
  logic [DIV_W-1:0]  dvd_s, dvd_t;
  logic              done_s, done_t;
  logic [PINT_W-1:0] rem_s, rem_t;
  logic [FRAC_W-1:0] fmask_s, fmask_t;

  function automatic logic [POS_W-1:0] col_adv(input logic [POS_W-1:0] pos,
                                               input logic signed [STEP_W-1:0] step,
                                               input logic [POS_W-1:0] per);
    logic signed [ADV_W-1:0] n;
    logic signed [ADV_W-1:0] p;
    n = $signed(ADV_W'(pos)) + ADV_W'(step);
    p = $signed(ADV_W'(per));
    if (!step[STEP_W-1] && (step != '0)) begin
      if (n >= p) begin
        n = n - p;
      end
    end else if (n < $signed(ADV_W'(0))) begin
      n = n + p;
    end
    return n[POS_W-1:0];
  endfunction

  // Handshake and stage control
  assign sweep_idle = (sw_q == SW_IDLE);
  assign fire       = in_vld_q && (!out_vld_q || m_ready_i);
  assign s_ready_o  = sweep_idle && !cfg_we_i && (!in_vld_q || fire);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_ready_o) begin
        in_vld_q <= s_valid_i;
      end else if (fire) begin
        in_vld_q <= 1'b0;
      end
      if (fire) begin
        out_vld_q <= 1'b1;
      end else if (m_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_valid_i && s_ready_o) begin
      in_nf_q <= s_new_frame_i;
    end
    if (fire) begin
      res_q <= res_d;
    end
  end

  // Address datapath
  always_comb begin
    cur_s   = in_nf_q ? start_s_red_q : pix_s_q;
    cur_t   = in_nf_q ? start_t_red_q : pix_t_q;
    base_s  = in_nf_q ? start_s_red_q : row_s_q;
    base_t  = in_nf_q ? start_t_red_q : row_t_q;
    col_cur = in_nf_q ? '0 : col_q;
    row_cur = in_nf_q ? '0 : row_q;

    rend = CMPC_W'(col_cur) >= CMPC_W'(ps_int_i);
    fend = rend && (CMPC_W'(row_cur) >= CMPC_W'(pt_int_i));

    ps_full = {ps_int_i, {FRAC_W{1'b0}}};
    pt_full = {pt_int_i, {FRAC_W{1'b0}}};

    idx_c = IDXC_W'(cur_t[POS_W-1:FRAC_W]) * IDXC_W'(width_i)
          + IDXC_W'(cur_s[POS_W-1:FRAC_W]);

    res_d.source_index = skip_i ? '0 : idx_c[IDX_W-1:0];
    res_d.frac_s       = skip_i ? '0 : cur_s[FRAC_W-1:FRAC_W-FRAC_OUT_W];
    res_d.frac_t       = skip_i ? '0 : cur_t[FRAC_W-1:FRAC_W-FRAC_OUT_W];
    res_d.row_end      = rend;
    res_d.frame_end    = fend;
    res_d.skipped      = skip_i;

    sum_s   = {1'b0, base_s} + {1'b0, step_s_red_q};
    sum_t   = {1'b0, base_t} + {1'b0, step_t_red_q};
    rnext_s = (sum_s >= {1'b0, ps_full}) ? POS_W'(sum_s - {1'b0, ps_full}) : POS_W'(sum_s);
    rnext_t = (sum_t >= {1'b0, pt_full}) ? POS_W'(sum_t - {1'b0, pt_full}) : POS_W'(sum_t);

    if (rend) begin
      col_n = '0;
      row_n = fend ? '0 : row_cur + CNT_W'(1);
      if (skip_i) begin
        rs_n = base_s;
        rt_n = base_t;
        ps_n = cur_s;
        pt_n = cur_t;
      end else begin
        rs_n = fend ? start_s_red_q : rnext_s;
        rt_n = fend ? start_t_red_q : rnext_t;
        ps_n = rs_n;
        pt_n = rt_n;
      end
    end else begin
      col_n = col_cur + CNT_W'(1);
      row_n = row_cur;
      rs_n  = base_s;
      rt_n  = base_t;
      ps_n  = skip_i ? cur_s : col_adv(cur_s, regs_i.col_step_s, ps_full);
      pt_n  = skip_i ? cur_t : col_adv(cur_t, regs_i.col_step_t, pt_full);
    end
  end

  // Reduction sweep after a register write
  always_comb begin
    sw_d       = sw_q;
    slot_d     = slot_q;
    lane_start = 1'b0;
    wb         = 1'b0;
    unique case (sw_q)
      SW_IDLE: begin
      end
      SW_WAIT: begin
        sw_d   = SW_LOAD;
        slot_d = SL_START;
      end
      SW_LOAD: begin
        lane_start = 1'b1;
        sw_d       = SW_RUN;
      end
      SW_RUN: begin
        if (done_s && done_t) begin
          wb = 1'b1;
          unique case (slot_q)
            SL_START: begin
              slot_d = SL_STEP;
              sw_d   = SW_LOAD;
            end
            SL_STEP: begin
              slot_d = SL_ROW;
              sw_d   = SW_LOAD;
            end
            SL_ROW: begin
              slot_d = SL_PIX;
              sw_d   = SW_LOAD;
            end
            SL_PIX: begin
              sw_d = SW_IDLE;
            end
            default: sw_d = SW_IDLE;
          endcase
        end
      end
      default: sw_d = SW_IDLE;
    endcase
    if (cfg_we_i) begin
      sw_d   = SW_WAIT;
      slot_d = SL_START;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q   <= SW_IDLE;
      slot_q <= SL_START;
    end else begin
      sw_q   <= sw_d;
      slot_q <= slot_d;
    end
  end

  always_comb begin
    unique case (slot_q)
      SL_START: begin
        dvd_s = DIV_W'(regs_i.start_s[REG_W-1:FRAC_W]);
        dvd_t = DIV_W'(regs_i.start_t[REG_W-1:FRAC_W]);
      end
      SL_STEP: begin
        dvd_s = DIV_W'(regs_i.row_step_s[REG_W-1:FRAC_W]);
        dvd_t = DIV_W'(regs_i.row_step_t[REG_W-1:FRAC_W]);
      end
      SL_ROW: begin
        dvd_s = DIV_W'(row_s_q[POS_W-1:FRAC_W]);
        dvd_t = DIV_W'(row_t_q[POS_W-1:FRAC_W]);
      end
      SL_PIX: begin
        dvd_s = DIV_W'(pix_s_q[POS_W-1:FRAC_W]);
        dvd_t = DIV_W'(pix_t_q[POS_W-1:FRAC_W]);
      end
      default: begin
        dvd_s = '0;
        dvd_t = '0;
      end
    endcase
  end

  rtaw_rem #(
    .DIV_W (DIV_W),
    .REM_W (PINT_W)
  ) u_rem_s (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (lane_start),
    .dividend_i (dvd_s),
    .divisor_i  (ps_int_i),
    .done_o     (done_s),
    .rem_o      (rem_s)
  );

  rtaw_rem #(
    .DIV_W (DIV_W),
    .REM_W (PINT_W)
  ) u_rem_t (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (lane_start),
    .dividend_i (dvd_t),
    .divisor_i  (pt_int_i),
    .done_o     (done_t),
    .rem_o      (rem_t)
  );

  // A zero period reduces every position to zero, fraction included.
  assign fmask_s = (ps_int_i == '0) ? '0 : '1;
  assign fmask_t = (pt_int_i == '0) ? '0 : '1;

  // Walk state and reduced register copies
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_s_q       <= '0;
      row_t_q       <= '0;
      pix_s_q       <= '0;
      pix_t_q       <= '0;
      col_q         <= '0;
      row_q         <= '0;
      start_s_red_q <= POS_W'(RST_START_S);
      start_t_red_q <= POS_W'(RST_START_T);
      step_s_red_q  <= POS_W'(RST_ROW_STEP_S);
      step_t_red_q  <= POS_W'(RST_ROW_STEP_T);
    end else if (fire) begin
      row_s_q <= rs_n;
      row_t_q <= rt_n;
      pix_s_q <= ps_n;
      pix_t_q <= pt_n;
      col_q   <= col_n;
      row_q   <= row_n;
    end else if (wb) begin
      unique case (slot_q)
        SL_START: begin
          start_s_red_q <= {rem_s, regs_i.start_s[FRAC_W-1:0] & fmask_s};
          start_t_red_q <= {rem_t, regs_i.start_t[FRAC_W-1:0] & fmask_t};
        end
        SL_STEP: begin
          step_s_red_q <= {rem_s, regs_i.row_step_s[FRAC_W-1:0] & fmask_s};
          step_t_red_q <= {rem_t, regs_i.row_step_t[FRAC_W-1:0] & fmask_t};
        end
        SL_ROW: begin
          row_s_q <= {rem_s, row_s_q[FRAC_W-1:0] & fmask_s};
          row_t_q <= {rem_t, row_t_q[FRAC_W-1:0] & fmask_t};
        end
        SL_PIX: begin
          pix_s_q <= {rem_s, pix_s_q[FRAC_W-1:0] & fmask_s};
          pix_t_q <= {rem_t, pix_t_q[FRAC_W-1:0] & fmask_t};
        end
        default: begin
          pix_t_q <= pix_t_q;
        end
      endcase
    end
  end

  assign m_valid_o = out_vld_q;
  assign m_res_o   = res_q;

endmodule

// ===== rtl/rotozoom_texture_address_walker.sv =====
`timescale 1ns / 1ps
// Top level of the rotozoom texture address walker: configuration registers
// and the coordinate walk. Depends on rtaw_pkg, rtaw_cfg, rtaw_walk, rtaw_rem.
//
//   Channel   Direction  Handshake                  Content
//   s_axis    in         tvalid / tready            one request per output pixel
//   m_axis    out        tvalid / tready            source address and weights
//   cfg       in         cfg_we_i, no wait          register index and value
//
// One request per clock unless the output stalls or a register write or sweep
// holds off input; a request passes the input stage, then the result register.
// Reset leaves the registers at their reset values and the walk at row zero.
// After a register write, input is held off while the remainder units reduce
// the stored start, row step, row and pixel positions in turn.
// A stalled output holds the result; the input stage keeps taking requests
// until both stages are full.
module rotozoom_texture_address_walker import rtaw_pkg::*; #(
  parameter int MAX_DIM = 4096
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [0] new_frame
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [23:0] source_index, [31:24] frac_s,
                                                 // [39:32] frac_t
  output logic                   m_axis_tlast,   // row_end
  output logic [OUT_TUSER_W-1:0] m_axis_tuser,   // [0] frame_end, [1] skipped
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int PINT_W = $clog2(MAX_DIM);

  cfg_regs_t         regs;
  logic [DIM_W-1:0]  width;
  logic [PINT_W-1:0] ps_int, pt_int;
  logic              skip;
  res_t              res;

  rtaw_cfg #(
    .MAX_DIM (MAX_DIM)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .regs_o     (regs),
    .width_o    (width),
    .ps_int_o   (ps_int),
    .pt_int_o   (pt_int),
    .skip_o     (skip)
  );

  rtaw_walk #(
    .MAX_DIM (MAX_DIM)
  ) u_walk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_valid_i     (s_axis_tvalid),
    .s_ready_o     (s_axis_tready),
    .s_new_frame_i (s_axis_tdata[0]),
    .m_valid_o     (m_axis_tvalid),
    .m_ready_i     (m_axis_tready),
    .m_res_o       (res),
    .cfg_we_i      (cfg_we_i),
    .regs_i        (regs),
    .width_i       (width),
    .ps_int_i      (ps_int),
    .pt_int_i      (pt_int),
    .skip_i        (skip)
  );

  assign m_axis_tdata = {res.frac_t, res.frac_s, res.source_index};
  assign m_axis_tlast = res.row_end;
  assign m_axis_tuser = {res.skipped, res.frame_end};

endmodule

// ===== tb/rotozoom_texture_address_walker_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for rotozoom_texture_address_walker: a directed table, then random
// register settings and pixel requests under random stalls, checked against a local model.
// Depends on rtaw_pkg and the walker RTL only.
module rotozoom_texture_address_walker_tb;
  import rtaw_pkg::*;

  localparam longint DIM_MAX = 4096;
  localparam int     NUM_PH  = 30;
  localparam int     DIR_ROWS = 26;

  typedef enum logic {ROW_REG, ROW_PIX} row_kind_e;

  typedef struct {
    row_kind_e             kind;
    cfg_idx_e              reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    logic                  nf;
    int                    reps;
    bit                    typed;
    res_t                  want;
  } dir_row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // [0] new_frame
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;        // [23:0] source_index, [31:24] frac_s,
                                               // [39:32] frac_t
  logic                   m_axis_tlast;        // row_end
  logic [OUT_TUSER_W-1:0] m_axis_tuser;        // [0] frame_end, [1] skipped
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i = '0;

  longint wid_reg = RST_FRAME_WIDTH;
  longint hgt_reg = RST_FRAME_HEIGHT;
  longint step_cs = $signed(RST_COL_STEP_S);
  longint step_ct = $signed(RST_COL_STEP_T);
  longint step_rs = RST_ROW_STEP_S;
  longint step_rt = RST_ROW_STEP_T;
  longint org_s   = RST_START_S;
  longint org_t   = RST_START_T;

  longint line_s = 0;
  longint line_t = 0;
  longint cur_s  = 0;
  longint cur_t  = 0;
  logic [CNT_W-1:0] col_pos = '0;
  logic [CNT_W-1:0] row_pos = '0;

  res_t     pending_addr [$];
  int       n_err = 0;
  int       snd_idle = 9;
  int       rcv_idle = 71;
  bit       dirty = 0;
  bit       we_high = 0;
  dir_row_t dir_tab [DIR_ROWS];

  rotozoom_texture_address_walker dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  function automatic longint clamp_dim(longint d);
    if (d < 1) return 1;
    if (d > DIM_MAX) return DIM_MAX;
    return d;
  endfunction

  function automatic longint wrap_pos(longint v, longint p);
    return (p == 0) ? 0 : v % p;
  endfunction

  function automatic longint step_wrap(longint pos, longint step, longint p);
    longint n;
    n = pos + step;
    if (step > 0) begin
      if (n >= p) n -= p;
    end else if (n < 0) begin
      n += p;
    end
    return n;
  endfunction

  function automatic longint s_period();
    return (clamp_dim(wid_reg) - 1) << FRAC_W;
  endfunction

  function automatic longint t_period();
    return (clamp_dim(hgt_reg) - 1) << FRAC_W;
  endfunction

  function automatic void apply_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_FRAME_WIDTH:  wid_reg = val[DIM_REG_W-1:0];
      CFG_FRAME_HEIGHT: hgt_reg = val[DIM_REG_W-1:0];
      CFG_COL_STEP_S:   step_cs = $signed(val[STEP_W-1:0]);
      CFG_COL_STEP_T:   step_ct = $signed(val[STEP_W-1:0]);
      CFG_ROW_STEP_S:   step_rs = val;
      CFG_ROW_STEP_T:   step_rt = val;
      CFG_START_S:      org_s = val;
      CFG_START_T:      org_t = val;
      default: ;
    endcase
  endfunction

  task automatic walk_pixel(input logic nf, output res_t r);
    longint w, h, ps, pt, s, t, idx;
    bit skip, rend, fend;
    w = clamp_dim(wid_reg);
    h = clamp_dim(hgt_reg);
    ps = (w - 1) << FRAC_W;
    pt = (h - 1) << FRAC_W;
    s = 0;
    t = 0;
    idx = 0;
    if (nf) begin
      col_pos = '0;
      row_pos = '0;
      line_s = wrap_pos(org_s, ps);
      line_t = wrap_pos(org_t, pt);
      cur_s = line_s;
      cur_t = line_t;
    end
    skip = (step_cs <= -ps) || (step_cs >= ps) || (step_ct <= -pt) || (step_ct >= pt);
    rend = col_pos >= w - 1;
    fend = rend && (row_pos >= h - 1);
    if (!skip) begin
      s = wrap_pos(cur_s, ps);
      t = wrap_pos(cur_t, pt);
      idx = (s >> FRAC_W) + (t >> FRAC_W) * w;
    end
    r.source_index = idx[IDX_W-1:0];
    r.frac_s = s[15:8];
    r.frac_t = t[15:8];
    r.row_end = rend;
    r.frame_end = fend;
    r.skipped = skip;
    if (rend) begin
      col_pos = '0;
      row_pos = fend ? '0 : row_pos + 1'b1;
      if (!skip) begin
        if (fend) begin
          line_s = wrap_pos(org_s, ps);
          line_t = wrap_pos(org_t, pt);
        end else begin
          line_s = (wrap_pos(line_s, ps) + wrap_pos(step_rs, ps)) % ps;
          line_t = (wrap_pos(line_t, pt) + wrap_pos(step_rt, pt)) % pt;
        end
        cur_s = line_s;
        cur_t = line_t;
      end
    end else begin
      col_pos = col_pos + 1'b1;
      if (!skip) begin
        cur_s = step_wrap(s, step_cs, ps);
        cur_t = step_wrap(t, step_ct, pt);
      end
    end
  endtask

  task automatic compare_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      n_err++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  always @(posedge clk_i) begin : check_results
    res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_addr.size() == 0) begin
        $error("result with no request pending");
        n_err++;
      end else begin
        want = pending_addr.pop_front();
        compare_field("source_index", want.source_index, m_axis_tdata[23:0]);
        compare_field("frac_s", want.frac_s, m_axis_tdata[31:24]);
        compare_field("frac_t", want.frac_t, m_axis_tdata[39:32]);
        compare_field("row_end", want.row_end, m_axis_tlast);
        compare_field("frame_end", want.frame_end, m_axis_tuser[0]);
        compare_field("skipped", want.skipped, m_axis_tuser[1]);
      end
    end
  end

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    we_high = 1;
    apply_reg(idx, val);
  endtask

  task automatic send_pixel(input logic nf, input bit typed, input res_t want);
    res_t r;
    int gap;
    if (we_high) begin
      @(posedge clk_i);
      cfg_we_i <= 1'b0;
      we_high = 0;
    end
    gap = 0;
    while ($urandom_range(99) < snd_idle) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {{(IN_TDATA_W-1){1'b0}}, nf};
    do @(posedge clk_i); while (!s_axis_tready);
    walk_pixel(nf, r);
    pending_addr.push_back(typed ? want : r);
    dirty = 1;
  endtask

  task automatic settle(input int tail);
    s_axis_tvalid <= 1'b0;
    while (pending_addr.size() != 0) @(posedge clk_i);
    repeat (tail) @(posedge clk_i);
    dirty = 0;
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_dim();
    case ($urandom_range(24))
      0: return '0;
      1: return CFG_DATA_W'(1);
      2: return CFG_DATA_W'(DIM_MAX);
      3: return CFG_DATA_W'(13'h1fff);
      4: return CFG_DATA_W'($urandom);
      default: return CFG_DATA_W'($urandom_range(2, 12));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_col_step(longint p);
    longint lim, v;
    lim = (p - 1 < 8388607) ? p - 1 : 8388607;
    case ($urandom_range(15))
      0: v = p;
      1: v = -p;
      2: v = lim;
      3: v = -lim;
      4: v = $urandom;
      default: begin
        v = (lim > 0) ? $urandom_range(int'(lim)) : 0;
        if ($urandom_range(1)) v = -v;
      end
    endcase
    return {4'($urandom), v[STEP_W-1:0]};
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_pos(longint p);
    longint v;
    case ($urandom_range(7))
      0: v = $urandom;
      1: v = (p > 0) ? p - 1 : 0;
      2: v = p;
      3: v = 0;
      default: v = (p > 0) ? $urandom % p : $urandom;
    endcase
    return v[CFG_DATA_W-1:0];
  endfunction

  task automatic random_setup();
    if ($urandom_range(1)) write_reg(CFG_FRAME_WIDTH, pick_dim());
    if ($urandom_range(1)) write_reg(CFG_FRAME_HEIGHT, pick_dim());
    if ($urandom_range(9) < 7) write_reg(CFG_COL_STEP_S, pick_col_step(s_period()));
    if ($urandom_range(9) < 7) write_reg(CFG_COL_STEP_T, pick_col_step(t_period()));
    if ($urandom_range(1)) write_reg(CFG_ROW_STEP_S, pick_pos(s_period()));
    if ($urandom_range(1)) write_reg(CFG_ROW_STEP_T, pick_pos(t_period()));
    if ($urandom_range(1)) write_reg(CFG_START_S, pick_pos(s_period()));
    if ($urandom_range(1)) write_reg(CFG_START_T, pick_pos(t_period()));
  endtask

  function automatic dir_row_t reg_row(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
    dir_row_t row;
    row = '{ROW_REG, idx, val, 1'b0, 0, 1'b0, '0};
    return row;
  endfunction

  function automatic dir_row_t pix_row(logic nf, int reps);
    dir_row_t row;
    row = '{ROW_PIX, CFG_FRAME_WIDTH, '0, nf, reps, 1'b0, '0};
    return row;
  endfunction

  function automatic dir_row_t chk_row(logic nf, res_t want);
    dir_row_t row;
    row = '{ROW_PIX, CFG_FRAME_WIDTH, '0, nf, 1, 1'b1, want};
    return row;
  endfunction

  initial begin
    #2_000_000;
    $display("rotozoom_texture_address_walker_tb NOT OK");
    $finish;
  end

  initial begin
    logic nf;
    int   mode;
    int   n_pix;
    dir_tab = '{
      chk_row(1'b0, res_t'{24'd0, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0}),
      chk_row(1'b0, res_t'{24'd1, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0}),
      chk_row(1'b1, res_t'{24'd0, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0}),
      reg_row(CFG_FRAME_WIDTH, 28'd0),
      reg_row(CFG_FRAME_HEIGHT, 28'd0),
      chk_row(1'b0, res_t'{24'd0, 8'h00, 8'h00, 1'b1, 1'b1, 1'b1}),
      reg_row(CFG_FRAME_WIDTH, 28'hfffffff),
      reg_row(CFG_FRAME_HEIGHT, 28'd4),
      pix_row(1'b1, 2),
      reg_row(CFG_FRAME_WIDTH, 28'd4),
      reg_row(CFG_FRAME_HEIGHT, 28'd3),
      reg_row(CFG_START_S, 28'hfffffff),
      reg_row(CFG_START_T, 28'hfffffff),
      chk_row(1'b1, res_t'{24'd4, 8'hff, 8'hff, 1'b0, 1'b0, 1'b0}),
      reg_row(CFG_COL_STEP_S, 28'h07fffff),
      pix_row(1'b0, 1),
      reg_row(CFG_COL_STEP_S, 28'h0800000),
      pix_row(1'b0, 1),
      reg_row(CFG_COL_STEP_S, 28'h0fe8000),
      reg_row(CFG_COL_STEP_T, 28'h001ffff),
      reg_row(CFG_ROW_STEP_S, 28'hfffffff),
      reg_row(CFG_ROW_STEP_T, 28'h0018000),
      pix_row(1'b0, 10),
      pix_row(1'b1, 1),
      pix_row(1'b0, 3),
      pix_row(1'b1, 1)
    };

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_REG) begin
        if (dirty) settle(4);
        write_reg(dir_tab[i].reg_idx, dir_tab[i].reg_val);
      end else begin
        repeat (dir_tab[i].reps) send_pixel(dir_tab[i].nf, dir_tab[i].typed, dir_tab[i].want);
      end
    end

    for (int ph = 0; ph < NUM_PH; ph++) begin
      settle(4);
      mode = ph * 3 / NUM_PH;
      snd_idle = (mode == 0) ? 9 : (mode == 1) ? 71 : 0;
      rcv_idle = (mode == 0) ? 71 : (mode == 1) ? 9 : 0;
      random_setup();
      n_pix = $urandom_range(30, 56);
      for (int k = 0; k < n_pix; k++) begin
        if (k == 0) begin
          nf = ($urandom_range(3) != 0);
        end else if (col_pos == 0 && row_pos == 0) begin
          nf = ($urandom_range(4) != 0);
        end else begin
          nf = ($urandom_range(99) < 3);
        end
        send_pixel(nf, 1'b0, '0);
      end
    end

    settle(8);
    if (n_err == 0) begin
      $display("rotozoom_texture_address_walker_tb OK");
    end else begin
      $display("rotozoom_texture_address_walker_tb NOT OK");
    end
    $finish;
  end

endmodule
